[sv/mf3_pkg.sv]
`timescale 1ns / 1ps

package mf3_pkg;

    localparam int PIX_W        = 8;
    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = 12;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_INDEX_W  = 1;
    localparam int WINDOW_N     = 9;
    localparam int MEDIAN_IDX   = 4;
    localparam int QUEUE_DEPTH  = 2;
    localparam int WIDTH_RESET  = 512;
    localparam int HEIGHT_RESET = 512;
    localparam int MIN_SIDE     = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [WINDOW_N-1:0][PIX_W-1:0] pix9_t;

    typedef struct packed {
        pix9_t pix;
        logic  last;
    } q_item_t;

endpackage

[sv/mf3_if.sv]
`timescale 1ns / 1ps

interface mf3_pixel_if;
    logic          valid;
    logic          ready;
    mf3_pkg::pix_t pixel_value;
    logic          frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface mf3_median_if;
    logic          valid;
    logic          ready;
    mf3_pkg::pix_t median_value;
    logic          frame_last;

    modport source (output valid, output median_value, output frame_last, input ready);
    modport sink (input valid, input median_value, input frame_last, output ready);
endinterface

[sv/median_filter_3x3.sv]
`timescale 1ns / 1ps
// 3x3 median filter over a raster stream of 8-bit grey pixels.
// pixel_in: one pixel per request, valid/ready; frame_start marks the first
//   pixel of a frame and clears the row and column position.
// median_out: one median per interior pixel, (W-2) x (H-2) per frame, with
//   frame_last set on the final one.
// cfg_write_en/cfg_index/cfg_data: index 0 image_width, index 1 image_height;
//   write only while the stream is idle.
// Throughput: one pixel per clock while median_out is not stalled. The front
//   reads both line stores with a single registered read of a 1024 x 16
//   memory and writes them back as the pixel leaves the front stage; the
//   median network runs as a three-stage pipeline. The pixel that completes
//   a window passes the front stage, the queue and that pipeline to median_out.
// Reset: position counters, window and all valid flags clear; width and
//   height return to 512. Line stores are not cleared and hold garbage
//   until the first two rows of a frame have passed.
// Output stall: the output register holds its request; a two-entry queue
//   and the pipeline stages absorb requests until ready drops on pixel_in.
module median_filter_3x3 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [mf3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_data,
    mf3_pixel_if.sink                       pixel_in,
    mf3_median_if.source                    median_out
);

    logic             push_valid;
    logic             push_ready;
    mf3_pkg::q_item_t push_item;
    logic             pop_valid;
    logic             pop_ready;
    mf3_pkg::q_item_t pop_item;

    mf3_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_in     (pixel_in),
        .push_valid   (push_valid),
        .push_item    (push_item),
        .push_ready   (push_ready)
    );

    mf3_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    mf3_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready),
        .median_out (median_out)
    );

endmodule

[sv/mf3_front.sv]
`timescale 1ns / 1ps

module mf3_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [mf3_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]      cfg_data,
    mf3_pixel_if.sink                           pixel_in,
    output logic                                push_valid,
    output mf3_pkg::q_item_t                    push_item,
    input  logic                                push_ready
);

    localparam int COL_W = mf3_pkg::COL_W;
    localparam int ROW_W = mf3_pkg::ROW_W;
    localparam int PW    = mf3_pkg::PIX_W;

    function automatic logic [COL_W-1:0] clamp_last_col(
        input logic [mf3_pkg::WIDTH_REG_W-1:0] w
    );
        logic [COL_W-1:0] r;
        if (w < mf3_pkg::WIDTH_REG_W'(mf3_pkg::MIN_SIDE))
            r = COL_W'(mf3_pkg::MIN_SIDE - 1);
        else if (w > mf3_pkg::WIDTH_REG_W'(mf3_pkg::MAX_WIDTH))
            r = COL_W'(mf3_pkg::MAX_WIDTH - 1);
        else
            r = COL_W'(w - 1'b1);
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_last_row(
        input logic [mf3_pkg::HEIGHT_REG_W-1:0] h
    );
        logic [ROW_W-1:0] r;
        if (h < mf3_pkg::HEIGHT_REG_W'(mf3_pkg::MIN_SIDE))
            r = ROW_W'(mf3_pkg::MIN_SIDE - 1);
        else
            r = ROW_W'(h - 1'b1);
        return r;
    endfunction

    logic [COL_W-1:0] last_col_reg;
    logic [ROW_W-1:0] last_row_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    mf3_pkg::pix_t    s1_pixel_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [5:0][PW-1:0] win_reg, win_next;

    logic [2*PW-1:0]  line_mem [mf3_pkg::MAX_WIDTH];
    logic [2*PW-1:0]  line_rd_reg;
    logic             fwd_hit_reg, fwd_hit_next;
    logic [2*PW-1:0]  fwd_data_reg;

    logic             s1_fire;
    logic             accept;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic             emit_cur;
    logic             last_cur;
    logic [2*PW-1:0]  line_data;
    logic [2*PW-1:0]  wr_data;
    mf3_pkg::pix_t    up_px;
    mf3_pkg::pix_t    lo_px;

    assign s1_fire        = s1_valid_reg && (!s1_emit_reg || push_ready);
    assign pixel_in.ready = !s1_valid_reg || s1_fire;
    assign accept         = pixel_in.valid && pixel_in.ready;

    assign col_cur  = pixel_in.frame_start ? '0 : col_reg;
    assign row_cur  = pixel_in.frame_start ? '0 : row_reg;
    assign emit_cur = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
    assign last_cur = (row_cur >= last_row_reg) && (col_cur >= last_col_reg);

    always_comb
    begin
        if (col_cur >= last_col_reg)
        begin
            col_next = '0;
            row_next = (row_cur >= last_row_reg) ? '0 : row_cur + 1'b1;
        end
        else
        begin
            col_next = col_cur + 1'b1;
            row_next = row_cur;
        end
    end

    // line word: upper row in high byte, lower row in low byte
    assign line_data = fwd_hit_reg ? fwd_data_reg : line_rd_reg;
    assign up_px     = line_data[2*PW-1:PW];
    assign lo_px     = line_data[PW-1:0];
    assign wr_data   = {lo_px, s1_pixel_reg};
    assign win_next  = {s1_pixel_reg, lo_px, up_px, win_reg[5:3]};

    assign fwd_hit_next = s1_fire && (col_cur == s1_col_reg);

    assign push_valid     = s1_valid_reg && s1_emit_reg;
    assign push_item.pix  = {s1_pixel_reg, lo_px, up_px, win_reg};
    assign push_item.last = s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            line_mem[s1_col_reg] <= wr_data;
        if (accept)
            line_rd_reg <= line_mem[col_cur];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= wr_data;
            s1_pixel_reg <= pixel_in.pixel_value;
            s1_col_reg   <= col_cur;
            s1_emit_reg  <= emit_cur;
            s1_last_reg  <= last_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= COL_W'(mf3_pkg::WIDTH_RESET - 1);
            last_row_reg <= ROW_W'(mf3_pkg::HEIGHT_RESET - 1);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                mf3_pkg::REG_IMAGE_WIDTH:
                    last_col_reg <= clamp_last_col(cfg_data[mf3_pkg::WIDTH_REG_W-1:0]);
                mf3_pkg::REG_IMAGE_HEIGHT:
                    last_row_reg <= clamp_last_row(cfg_data[mf3_pkg::HEIGHT_REG_W-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                fwd_hit_reg <= fwd_hit_next;
            end
            if (s1_fire)
                win_reg <= win_next;
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
        end
    end

endmodule

[sv/mf3_queue.sv]
`timescale 1ns / 1ps

module mf3_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  mf3_pkg::q_item_t push_item,
    output logic             push_ready,
    output logic             pop_valid,
    output mf3_pkg::q_item_t pop_item,
    input  logic             pop_ready
);

    localparam int DEPTH = mf3_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mf3_pkg::q_item_t q_mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = q_mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[sv/mf3_back.sv]
`timescale 1ns / 1ps

module mf3_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    input  mf3_pkg::q_item_t pop_item,
    output logic             pop_ready,
    mf3_median_if.source     median_out
);

    // compare-exchange: first index takes the smaller value
    function automatic mf3_pkg::pix9_t cx(input mf3_pkg::pix9_t p, input int a, input int b);
        mf3_pkg::pix_t t;
        if (p[a] > p[b])
        begin
            t    = p[a];
            p[a] = p[b];
            p[b] = t;
        end
        return p;
    endfunction

    function automatic mf3_pkg::pix9_t net_a(input mf3_pkg::pix9_t p);
        mf3_pkg::pix9_t q;
        q = cx(p, 1, 2); q = cx(q, 4, 5); q = cx(q, 7, 8);
        q = cx(q, 0, 1); q = cx(q, 3, 4); q = cx(q, 6, 7);
        q = cx(q, 1, 2); q = cx(q, 4, 5); q = cx(q, 7, 8);
        return q;
    endfunction

    function automatic mf3_pkg::pix9_t net_b(input mf3_pkg::pix9_t p);
        mf3_pkg::pix9_t q;
        q = cx(p, 0, 3); q = cx(q, 5, 8); q = cx(q, 4, 7);
        q = cx(q, 3, 6); q = cx(q, 1, 4); q = cx(q, 2, 5);
        q = cx(q, 4, 7);
        return q;
    endfunction

    function automatic mf3_pkg::pix9_t net_c(input mf3_pkg::pix9_t p);
        mf3_pkg::pix9_t q;
        q = cx(p, 4, 2); q = cx(q, 6, 4); q = cx(q, 4, 2);
        return q;
    endfunction

    logic           b1_valid_reg;
    mf3_pkg::pix9_t b1_pix_reg;
    logic           b1_last_reg;
    logic           b2_valid_reg;
    mf3_pkg::pix9_t b2_pix_reg;
    logic           b2_last_reg;
    logic           out_valid_reg;
    mf3_pkg::pix_t  out_median_reg;
    logic           out_last_reg;

    logic           out_ready;
    logic           b2_ready;
    logic           b1_ready;
    mf3_pkg::pix9_t b2_pix_next;
    mf3_pkg::pix9_t out_pix_next;

    assign out_ready = !out_valid_reg || median_out.ready;
    assign b2_ready  = !b2_valid_reg || out_ready;
    assign b1_ready  = !b1_valid_reg || b2_ready;
    assign pop_ready = b1_ready;

    assign b2_pix_next  = net_b(b1_pix_reg);
    assign out_pix_next = net_c(b2_pix_reg);

    assign median_out.valid        = out_valid_reg;
    assign median_out.median_value = out_median_reg;
    assign median_out.frame_last   = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (b1_ready)
        begin
            b1_pix_reg  <= net_a(pop_item.pix);
            b1_last_reg <= pop_item.last;
        end
        if (b2_ready)
        begin
            b2_pix_reg  <= b2_pix_next;
            b2_last_reg <= b1_last_reg;
        end
        if (out_ready)
        begin
            out_median_reg <= out_pix_next[mf3_pkg::MEDIAN_IDX];
            out_last_reg   <= b2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_ready)
                b1_valid_reg <= pop_valid;
            if (b2_ready)
                b2_valid_reg <= b1_valid_reg;
            if (out_ready)
                out_valid_reg <= b2_valid_reg;
        end
    end

endmodule

[sv/mf3_checker.sv]
`timescale 1ns / 1ps

module mf3_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [mf3_pkg::PIX_W-1:0] median_value,
    input logic                frame_last
);

    logic [31:0] taken_reg;
    logic [31:0] given_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
            given_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                taken_reg <= taken_reg + 1'b1;
            if (out_valid && out_ready)
                given_reg <= given_reg + 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("median request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(median_value) && $stable(frame_last))
        else $error("median payload changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> given_reg < taken_reg)
        else $error("more medians than pixels taken");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> taken_reg >= 32'd9)
        else $error("median before a full window could exist");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (pixel_in.valid),
    .in_ready     (pixel_in.ready),
    .out_valid    (median_out.valid),
    .out_ready    (median_out.ready),
    .median_value (median_out.median_value),
    .frame_last   (median_out.frame_last)
);

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PIPE_SETTLE  = 8;
    localparam int MAX_REPORTS  = 20;
    localparam int DIRECTED_N   = 29;
    localparam int RESET_PROBE  = 20;
    localparam int RANDOM_SETS  = 12;
    localparam int RANDOM_ITEMS = 55;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        mf3_pkg::pix_t median;
        logic          last;
    } median_rec_t;

    typedef struct packed {
        mf3_pkg::pix_t px;
        logic          start;
        logic          given;
        median_rec_t   rec;
    } pixel_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_en;
    logic [mf3_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data;

    mf3_pixel_if pixel_bus();
    mf3_median_if median_bus();

    median_filter_3x3 uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_in     (pixel_bus),
        .median_out   (median_bus)
    );

    // filter state as the block should hold it
    mf3_pkg::pix_t upper_line [mf3_pkg::MAX_WIDTH];
    mf3_pkg::pix_t lower_line [mf3_pkg::MAX_WIDTH];
    mf3_pkg::pix_t prior_columns [6];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    logic [mf3_pkg::WIDTH_REG_W-1:0] cfg_width =
        mf3_pkg::WIDTH_REG_W'(mf3_pkg::WIDTH_RESET);
    logic [mf3_pkg::HEIGHT_REG_W-1:0] cfg_height =
        mf3_pkg::HEIGHT_REG_W'(mf3_pkg::HEIGHT_RESET);

    median_rec_t expected_medians [$];
    median_rec_t got_rec;
    median_rec_t want_rec;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned medians_checked = 0;
    int unsigned pixels_sent = 0;
    int unsigned settings_count = 0;

    // three frames of 3x3: all white, all black (no frame_start, wraps), mixed
    // after two stray pixels that the restart discards
    pixel_row_t directed_rows [DIRECTED_N] = '{
        '{8'hFF, 1'b1, 1'b0, 9'h0}, '{8'hFF, 1'b0, 1'b0, 9'h0}, '{8'hFF, 1'b0, 1'b0, 9'h0},
        '{8'hFF, 1'b0, 1'b0, 9'h0}, '{8'hFF, 1'b0, 1'b0, 9'h0}, '{8'hFF, 1'b0, 1'b0, 9'h0},
        '{8'hFF, 1'b0, 1'b0, 9'h0}, '{8'hFF, 1'b0, 1'b0, 9'h0},
        '{8'hFF, 1'b0, 1'b1, {8'hFF, 1'b1}},
        '{8'h00, 1'b0, 1'b0, 9'h0}, '{8'h00, 1'b0, 1'b0, 9'h0}, '{8'h00, 1'b0, 1'b0, 9'h0},
        '{8'h00, 1'b0, 1'b0, 9'h0}, '{8'h00, 1'b0, 1'b0, 9'h0}, '{8'h00, 1'b0, 1'b0, 9'h0},
        '{8'h00, 1'b0, 1'b0, 9'h0}, '{8'h00, 1'b0, 1'b0, 9'h0},
        '{8'h00, 1'b0, 1'b1, {8'h00, 1'b1}},
        '{8'hA5, 1'b0, 1'b0, 9'h0}, '{8'h5A, 1'b0, 1'b0, 9'h0},
        '{8'h00, 1'b1, 1'b0, 9'h0}, '{8'hFF, 1'b0, 1'b0, 9'h0}, '{8'h80, 1'b0, 1'b0, 9'h0},
        '{8'h01, 1'b0, 1'b0, 9'h0}, '{8'hFE, 1'b0, 1'b0, 9'h0}, '{8'h7F, 1'b0, 1'b0, 9'h0},
        '{8'hC8, 1'b0, 1'b0, 9'h0}, '{8'h03, 1'b0, 1'b0, 9'h0}, '{8'h64, 1'b0, 1'b0, 9'h0}
    };

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    function automatic mf3_pkg::pix_t middle_of(input mf3_pkg::pix_t v [mf3_pkg::WINDOW_N]);
        int below;
        int not_above;
        for (int i = 0; i < mf3_pkg::WINDOW_N; i++)
        begin
            below = 0;
            not_above = 0;
            for (int j = 0; j < mf3_pkg::WINDOW_N; j++)
            begin
                if (v[j] < v[i])
                    below++;
                if (v[j] <= v[i])
                    not_above++;
            end
            if (below <= mf3_pkg::MEDIAN_IDX && not_above > mf3_pkg::MEDIAN_IDX)
                return v[i];
        end
        return v[0];
    endfunction

    task automatic predict_median(input mf3_pkg::pix_t px, input logic start,
                                  output logic hit, output median_rec_t rec);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        mf3_pkg::pix_t up;
        mf3_pkg::pix_t lo;
        mf3_pkg::pix_t nine [mf3_pkg::WINDOW_N];
        w = cfg_width;
        h = cfg_height;
        if (w < mf3_pkg::MIN_SIDE)
            w = mf3_pkg::MIN_SIDE;
        if (w > mf3_pkg::MAX_WIDTH)
            w = mf3_pkg::MAX_WIDTH;
        if (h < mf3_pkg::MIN_SIDE)
            h = mf3_pkg::MIN_SIDE;
        if (start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        up = '0;
        lo = '0;
        if (c < mf3_pkg::MAX_WIDTH)
        begin
            up = upper_line[c];
            lo = lower_line[c];
        end
        for (int k = 0; k < 6; k++)
            nine[k] = prior_columns[k];
        nine[6] = up;
        nine[7] = lo;
        nine[8] = px;
        hit = (row_pos >= 2) && (c >= 2);
        rec.median = middle_of(nine);
        rec.last = (row_pos >= h - 1) && (c >= w - 1);
        for (int k = 0; k < 3; k++)
            prior_columns[k] = prior_columns[k + 3];
        prior_columns[3] = up;
        prior_columns[4] = lo;
        prior_columns[5] = px;
        if (c < mf3_pkg::MAX_WIDTH)
        begin
            upper_line[c] = lo;
            lower_line[c] = px;
        end
        if (c >= w - 1)
        begin
            col_pos = 0;
            row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
        end
        else
            col_pos = c + 1;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        src_idle_pct = (mode == IDLE_SENDER) ? 56 : (mode == IDLE_BOTH) ? 10 : 0;
        snk_stall_pct = (mode == IDLE_RECEIVER) ? 56 : (mode == IDLE_BOTH) ? 10 : 0;
    endtask

    // called at a rising edge while pixel valid is low
    task automatic configure(input int unsigned w, input int unsigned h);
        cfg_write_en <= 1'b1;
        cfg_index <= mf3_pkg::REG_IMAGE_WIDTH;
        cfg_data <= mf3_pkg::CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= mf3_pkg::REG_IMAGE_HEIGHT;
        cfg_data <= mf3_pkg::CFG_DATA_W'(h);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cfg_width = mf3_pkg::WIDTH_REG_W'(w);
        cfg_height = mf3_pkg::HEIGHT_REG_W'(h);
        settings_count++;
    endtask

    task automatic send_pixel(input pixel_row_t row);
        logic hit;
        median_rec_t rec;
        while ($urandom_range(99) < src_idle_pct)
        begin
            pixel_bus.valid <= 1'b0;
            @(posedge clk);
        end
        predict_median(row.px, row.start, hit, rec);
        if (row.given)
            expected_medians.push_back(row.rec);
        else if (hit)
            expected_medians.push_back(rec);
        pixel_bus.valid <= 1'b1;
        pixel_bus.pixel_value <= row.px;
        pixel_bus.frame_start <= row.start;
        do
            @(posedge clk);
        while (!pixel_bus.ready);
        pixels_sent++;
    endtask

    function automatic mf3_pkg::pix_t random_pixel(input mf3_pkg::pix_t prev);
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2, 3: return prev;
            default: return mf3_pkg::pix_t'($urandom_range(255));
        endcase
    endfunction

    // raster stream; restart_odds > 0 throws in a stray frame_start now and then
    task automatic stream_pixels(input int unsigned count, input logic open_frame,
                                 input int unsigned restart_odds);
        pixel_row_t row;
        row = '0;
        for (int unsigned i = 0; i < count; i++)
        begin
            row.px = random_pixel(row.px);
            if (i == 0)
                row.start = open_frame;
            else
                row.start = (restart_odds != 0) && ($urandom_range(restart_odds - 1) == 0);
            send_pixel(row);
        end
        pixel_bus.valid <= 1'b0;
    endtask

    task automatic wait_for_medians();
        while (expected_medians.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    always @(posedge clk)
        median_bus.ready <= ($urandom_range(99) >= snk_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && median_bus.valid && median_bus.ready)
        begin
            got_rec.median = median_bus.median_value;
            got_rec.last = median_bus.frame_last;
            if (expected_medians.size() == 0)
                report_mismatch($sformatf("median %0d with none expected", got_rec.median));
            else
            begin
                want_rec = expected_medians.pop_front();
                if (got_rec.median !== want_rec.median)
                    report_mismatch($sformatf("median_value %0d, want %0d",
                                              got_rec.median, want_rec.median));
                if (got_rec.last !== want_rec.last)
                    report_mismatch($sformatf("frame_last %0b, want %0b",
                                              got_rec.last, want_rec.last));
            end
            medians_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned w;
        int unsigned h;
        rst_n <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index <= mf3_pkg::REG_IMAGE_WIDTH;
        cfg_data <= '0;
        pixel_bus.valid <= 1'b0;
        pixel_bus.pixel_value <= '0;
        pixel_bus.frame_start <= 1'b0;
        for (int k = 0; k < 6; k++)
            prior_columns[k] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset width: a few pixels of row 0, so no median yet
        set_idle(IDLE_NONE);
        stream_pixels(RESET_PROBE, 1'b1, 0);
        wait_for_medians();

        configure(3, 3);
        for (int i = 0; i < DIRECTED_N; i++)
            send_pixel(directed_rows[i]);
        pixel_bus.valid <= 1'b0;
        wait_for_medians();

        // stop mid-frame, then shrink both sides so the counters sit past the end
        set_idle(IDLE_SENDER);
        configure(8, 6);
        stream_pixels(30, 1'b1, 0);
        wait_for_medians();
        configure(4, 3);
        stream_pixels(40, 1'b0, 0);
        wait_for_medians();

        // out-of-range registers clamp to the minimum frame
        set_idle(IDLE_RECEIVER);
        configure(0, 0);
        stream_pixels(27, 1'b1, 0);
        wait_for_medians();
        configure(2, 1);
        stream_pixels(18, 1'b1, 0);
        wait_for_medians();

        // oversized width clamps to the line store size: still row 0
        set_idle(IDLE_BOTH);
        configure(12'h7FF, 3);
        stream_pixels(30, 1'b1, 0);
        wait_for_medians();
        // tallest frame: medians come without frame_last
        set_idle(IDLE_NONE);
        configure(1, 12'hFFF);
        stream_pixels(30, 1'b1, 0);
        wait_for_medians();

        for (int p = 0; p < RANDOM_SETS; p++)
        begin
            w = ($urandom_range(7) == 0) ? $urandom_range(17, 64) : $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            set_idle(idle_mode_t'(p % 4));
            configure(w, h);
            stream_pixels(RANDOM_ITEMS, 1'b1, 400);
            wait_for_medians();
        end

        if (expected_medians.size() != 0)
            report_mismatch($sformatf("%0d medians never arrived", expected_medians.size()));
        $display("run covered %0d pixels over %0d register settings, %0d medians checked",
                 pixels_sent, settings_count, medians_checked);
        $display("including clamped sizes, an oversized width, 4095 rows and mid-frame shrink");
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
